[sv/slw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slw_pkg
// Shared types, codes and defaults of the segmenting stop-and-wait link.
// ----------------------------------------------------------------------------
package slw_pkg;

   localparam int MAX_PAYLOAD_DEF = 30;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int ID_BITS_DEF     = 16;

   localparam int          TICK_W        = 24;
   localparam logic [23:0] TIMEOUT_RESET = 24'd100000;
   localparam logic [23:0] TICK_MAX      = 24'hFFFFFF;
   localparam int          CSR_AW        = 3;
   localparam logic [2:0]  CSR_TIMEOUT   = 3'd0;

   typedef enum logic [1:0] {
      OP_TX_BYTE   = 2'd0,
      OP_TICK      = 2'd1,
      OP_RX_HEADER = 2'd2,
      OP_RX_BYTE   = 2'd3
   } op_type;

   localparam logic [1:0] RX_DATA = 2'd0;
   localparam logic [1:0] RX_ACK  = 2'd1;

   typedef enum logic [2:0] {
      KIND_TX_DATA      = 3'd0,
      KIND_TX_ACK       = 3'd1,
      KIND_DELIVER      = 3'd2,
      KIND_ACK_IGNORED  = 3'd3,
      KIND_ACK_ACCEPTED = 3'd4,
      KIND_QUEUE_DROP   = 3'd5
   } kind_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  data_byte;
      logic        frame_end;
      logic [1:0]  rx_type;
      logic [15:0] rx_id;
      logic [4:0]  rx_size;
      logic        rx_final;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [15:0] packet_id;
      logic [4:0]  packet_size;
      logic        packet_final;
      logic [7:0]  out_byte;
      logic        delivered_frame_end;
      logic        last;
   } rsp_type;

   // command word handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [15:0] packet_id;
      logic [4:0]  packet_size;
      logic        packet_final;
      logic [7:0]  out_byte;
      logic        delivered_frame_end;
   } cmd_type;

   typedef enum logic {
      FR_IDLE   = 1'b0,
      FR_SETTLE = 1'b1
   } front_state_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SEND = 1'b1
   } back_state_type;

endpackage

[sv/segmenting_stop_and_wait_link.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmenting_stop_and_wait_link
// Stop-and-wait link layer: segments frames into queued packets, sends and
// resends the head packet on ticks, answers and delivers received packets.
// ----------------------------------------------------------------------------
// path: with the back end idle a single result passes the command queue and
// the output register; a send passes the queue, the burst state and the output
// and payload read registers, then bursts packet_size bytes, one per cycle
// throughput: one word per cycle, busy for one cycle after a commit or a
// popped ack while the head entry of the meta memory is read again; the
// two-entry command queue and a pending send of the slot being filled hold
// words off while bursts drain
// reset: synchronous; queue empty, next id 1, timeout 100000, no clearing pass
// ----------------------------------------------------------------------------
module segmenting_stop_and_wait_link #(
   parameter int MAX_PAYLOAD = slw_pkg::MAX_PAYLOAD_DEF,
   parameter int QUEUE_DEPTH = slw_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = slw_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  slw_pkg::req_type             req_item,
   output logic                         rsp_strobe,
   output slw_pkg::rsp_type             rsp_item,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [slw_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import slw_pkg::*;

   localparam int QW    = $clog2(QUEUE_DEPTH);
   localparam int PAW   = $clog2(QUEUE_DEPTH * MAX_PAYLOAD);
   localparam int PDEPTH = QUEUE_DEPTH * MAX_PAYLOAD;

   logic [23:0]    timeout_ff;
   logic           csr_wr;
   logic           slot_busy, fifo_hit, back_hit;
   logic           cmd_push, cmd_pop, cmd_empty, cmd_full;
   cmd_type        push_cmd, pop_cmd;
   logic [QW-1:0]  push_slot, pop_slot, tail_slot;
   logic           pay_wr_en;
   logic [PAW-1:0] pay_wr_addr, pay_rd_addr;
   logic [7:0]     pay_wr_data, pay_rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_TIMEOUT);
   assign csr_prdata = (csr_paddr == CSR_TIMEOUT) ? {8'd0, timeout_ff} : 32'd0;
   assign slot_busy  = fifo_hit || back_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr) begin
         timeout_ff <= csr_pwdata[23:0];
      end
   end

   slw_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .timeout     (timeout_ff),
      .slot_busy   (slot_busy),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .cmd_slot    (push_slot),
      .tail_slot   (tail_slot),
      .pay_wr_en   (pay_wr_en),
      .pay_wr_addr (pay_wr_addr),
      .pay_wr_data (pay_wr_data)
   );

   slw_cmd_fifo #(.QW(QW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .push_slot (push_slot),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .full      (cmd_full),
      .pop_cmd   (pop_cmd),
      .pop_slot  (pop_slot),
      .tail_slot (tail_slot),
      .slot_hit  (fifo_hit)
   );

   slw_ram #(.WIDTH(8), .DEPTH(PDEPTH)) u_payload (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (pay_wr_addr),
      .wr_data (pay_wr_data),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   slw_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd         (pop_cmd),
      .cmd_slot    (pop_slot),
      .cmd_pop     (cmd_pop),
      .tail_slot   (tail_slot),
      .slot_hit    (back_hit),
      .pay_rd_addr (pay_rd_addr),
      .pay_rd_data (pay_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule

[sv/slw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slw_ram
// Generic single write port memory with registered read.
// ----------------------------------------------------------------------------
module slw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/slw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slw_front
// Accepts words, builds packets, keeps queue and receive state, issues
// commands to the back end.
// ----------------------------------------------------------------------------
module slw_front #(
   parameter int MAX_PAYLOAD = slw_pkg::MAX_PAYLOAD_DEF,
   parameter int QUEUE_DEPTH = slw_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = slw_pkg::ID_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  slw_pkg::req_type                            req_item,
   input  logic [23:0]                                 timeout,
   input  logic                                        slot_busy,
   input  logic                                        cmd_full,
   output logic                                        cmd_push,
   output slw_pkg::cmd_type                            cmd,
   output logic [$clog2(QUEUE_DEPTH)-1:0]              cmd_slot,
   output logic [$clog2(QUEUE_DEPTH)-1:0]              tail_slot,
   output logic                                        pay_wr_en,
   output logic [$clog2(QUEUE_DEPTH*MAX_PAYLOAD)-1:0]  pay_wr_addr,
   output logic [7:0]                                  pay_wr_data
);
   import slw_pkg::*;

   localparam int QW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SW    = $clog2(MAX_PAYLOAD + 1);
   localparam int PAW   = $clog2(QUEUE_DEPTH * MAX_PAYLOAD);
   localparam int MW    = ID_BITS + SW + 1;
   localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;
   localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
   localparam logic [SW-1:0] MP        = SW'(MAX_PAYLOAD);

   front_state_type state_ff, state_in;
   logic [QW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;
   logic [SW-1:0]      build_ff, build_in;
   logic               lost_ff, lost_in;
   logic [23:0]        elapsed_ff, elapsed_in;
   logic               sent_ff, sent_in;
   logic [SW-1:0]      rx_rem_ff, rx_rem_in;
   logic               rx_final_ff, rx_final_in;

   logic               accept;
   logic               reload;
   logic               meta_wr;
   logic [MW-1:0]      meta_wdata, meta_rdata;
   logic [ID_BITS-1:0] head_id;
   logic [SW-1:0]      head_size;
   logic               head_final;
   logic               full;
   logic [SW-1:0]      build_next;
   logic               lost_now;
   logic [23:0]        elapsed_next;
   logic [SW-1:0]      rx_size_w;

   slw_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_meta (
      .clock   (clock),
      .wr_en   (meta_wr),
      .wr_addr (tail_ff),
      .wr_data (meta_wdata),
      .rd_addr (head_ff),
      .rd_data (meta_rdata)
   );

   assign {head_id, head_size, head_final} = meta_rdata;
   assign accept     = start && !busy;
   assign full       = (count_ff == FULL_CNT);
   assign build_next = build_ff + SW'(1);
   assign lost_now   = lost_ff || full || (build_ff >= MP);
   assign elapsed_next = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + 24'd1;
   assign rx_size_w  = (32'(req_item.rx_size) > 32'(MAX_PAYLOAD))
                       ? MP : SW'(req_item.rx_size);
   assign tail_slot  = tail_ff;
   assign pay_wr_addr = PAW'(tail_ff) * PAW'(MAX_PAYLOAD) + PAW'(build_ff);
   assign pay_wr_data = req_item.data_byte;
   assign meta_wdata  = {next_id_ff, build_next, req_item.frame_end};

   // next state
   always_comb begin
      unique case (state_ff)
         FR_IDLE:   state_in = reload ? FR_SETTLE : FR_IDLE;
         FR_SETTLE: state_in = FR_IDLE;
         default:   state_in = FR_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      unique case (state_ff)
         FR_IDLE:   busy = cmd_full || slot_busy;
         FR_SETTLE: busy = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      next_id_in  = next_id_ff;
      build_in    = build_ff;
      lost_in     = lost_ff;
      elapsed_in  = elapsed_ff;
      sent_in     = sent_ff;
      rx_rem_in   = rx_rem_ff;
      rx_final_in = rx_final_ff;
      reload      = 1'b0;
      meta_wr     = 1'b0;
      pay_wr_en   = 1'b0;
      cmd_push    = 1'b0;
      cmd         = '0;
      cmd.kind    = KIND_TX_DATA;
      cmd_slot    = head_ff;
      if (accept) begin
         unique case (op_type'(req_item.operation))
            OP_TX_BYTE: begin
               pay_wr_en = !full && (build_ff < MP);
               if (build_next >= MP || req_item.frame_end) begin
                  if (lost_now) begin
                     cmd_push             = 1'b1;
                     cmd.kind             = KIND_QUEUE_DROP;
                     cmd.packet_id        = 16'(next_id_ff);
                     cmd.packet_size      = 5'(build_next);
                     cmd.packet_final     = req_item.frame_end;
                  end else begin
                     meta_wr    = 1'b1;
                     reload     = 1'b1;
                     tail_in    = (tail_ff == LAST_SLOT) ? '0 : tail_ff + QW'(1);
                     count_in   = count_ff + CW'(1);
                     next_id_in = next_id_ff + ID_BITS'(1);
                  end
                  build_in = '0;
                  lost_in  = 1'b0;
               end else begin
                  build_in = build_next;
                  lost_in  = lost_now;
               end
            end
            OP_TICK: begin
               cmd.packet_id    = 16'(head_id);
               cmd.packet_size  = 5'(head_size);
               cmd.packet_final = head_final;
               if (count_ff == '0) begin
                  elapsed_in = '0;
               end else if (!sent_ff || elapsed_next > timeout) begin
                  cmd_push   = 1'b1;
                  sent_in    = 1'b1;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = elapsed_next;
               end
            end
            OP_RX_HEADER: begin
               cmd.packet_id = req_item.rx_id;
               if (req_item.rx_type == RX_DATA) begin
                  cmd_push    = 1'b1;
                  cmd.kind    = KIND_TX_ACK;
                  rx_rem_in   = rx_size_w;
                  rx_final_in = req_item.rx_final;
               end else if (req_item.rx_type == RX_ACK) begin
                  cmd_push = 1'b1;
                  if (count_ff != '0 && CMP_W'(head_id) == CMP_W'(req_item.rx_id)) begin
                     cmd.kind   = KIND_ACK_ACCEPTED;
                     reload     = 1'b1;
                     head_in    = (head_ff == LAST_SLOT) ? '0 : head_ff + QW'(1);
                     count_in   = count_ff - CW'(1);
                     sent_in    = 1'b0;
                     elapsed_in = '0;
                  end else begin
                     cmd.kind = KIND_ACK_IGNORED;
                  end
               end
            end
            OP_RX_BYTE: begin
               if (rx_rem_ff != '0) begin
                  cmd_push                = 1'b1;
                  cmd.kind                = KIND_DELIVER;
                  cmd.out_byte            = req_item.data_byte;
                  cmd.delivered_frame_end = (rx_rem_ff == SW'(1)) && rx_final_ff;
                  rx_rem_in               = rx_rem_ff - SW'(1);
               end
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FR_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         next_id_ff  <= ID_BITS'(1);
         build_ff    <= '0;
         lost_ff     <= 1'b0;
         elapsed_ff  <= '0;
         sent_ff     <= 1'b0;
         rx_rem_ff   <= '0;
         rx_final_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         next_id_ff  <= next_id_in;
         build_ff    <= build_in;
         lost_ff     <= lost_in;
         elapsed_ff  <= elapsed_in;
         sent_ff     <= sent_in;
         rx_rem_ff   <= rx_rem_in;
         rx_final_ff <= rx_final_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count overflow");
   a_sent_nonempty: assert property (@(posedge clock) disable iff (reset)
      sent_ff |-> count_ff != '0) else $error("sent flag with empty queue");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff) else $error("empty queue pointers differ");

endmodule

[sv/slw_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slw_cmd_fifo
// Two-entry command queue between front and back; flags queued sends of
// the slot that the front is filling.
// ----------------------------------------------------------------------------
module slw_cmd_fifo #(
   parameter int QW = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  slw_pkg::cmd_type push_cmd,
   input  logic [QW-1:0]    push_slot,
   input  logic             pop,
   output logic             empty,
   output logic             full,
   output slw_pkg::cmd_type pop_cmd,
   output logic [QW-1:0]    pop_slot,
   input  logic [QW-1:0]    tail_slot,
   output logic             slot_hit
);
   import slw_pkg::*;

   cmd_type       ent_ff  [2];
   logic [QW-1:0] slot_ff [2];
   logic [1:0]    val_ff, val_in;
   logic          rd_ff, rd_in, wr_ff, wr_in;

   assign empty    = !val_ff[rd_ff];
   assign full     = val_ff[wr_ff];
   assign pop_cmd  = ent_ff[rd_ff];
   assign pop_slot = slot_ff[rd_ff];

   always_comb begin
      slot_hit = 1'b0;
      for (int i = 0; i < 2; i++) begin
         if (val_ff[i] && ent_ff[i].kind == KIND_TX_DATA && slot_ff[i] == tail_slot) begin
            slot_hit = 1'b1;
         end
      end
   end

   always_comb begin
      val_in = val_ff;
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      if (pop && !empty) begin
         val_in[rd_ff] = 1'b0;
         rd_in         = !rd_ff;
      end
      if (push && !full) begin
         val_in[wr_ff] = 1'b1;
         wr_in         = !wr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         ent_ff[wr_ff]  <= push_cmd;
         slot_ff[wr_ff] <= push_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         val_ff <= val_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("command pushed into full queue");

endmodule

[sv/slw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slw_back
// Executes commands: single results at once, packet sends as a burst of
// payload reads, one byte a cycle.
// ----------------------------------------------------------------------------
module slw_back #(
   parameter int MAX_PAYLOAD = slw_pkg::MAX_PAYLOAD_DEF,
   parameter int QUEUE_DEPTH = slw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       cmd_empty,
   input  slw_pkg::cmd_type                           cmd,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]             cmd_slot,
   output logic                                       cmd_pop,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]             tail_slot,
   output logic                                       slot_hit,
   output logic [$clog2(QUEUE_DEPTH*MAX_PAYLOAD)-1:0] pay_rd_addr,
   input  logic [7:0]                                 pay_rd_data,
   output logic                                       rsp_strobe,
   output slw_pkg::rsp_type                           rsp_item
);
   import slw_pkg::*;

   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int SW  = $clog2(MAX_PAYLOAD + 1);
   localparam int PAW = $clog2(QUEUE_DEPTH * MAX_PAYLOAD);

   back_state_type state_ff, state_in;
   cmd_type        burst_ff;
   logic [QW-1:0]  slot_ff;
   logic [PAW-1:0] base_ff;
   logic [SW-1:0]  idx_ff, idx_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;
   logic           from_ram_ff, from_ram_in;
   logic           burst_last;
   logic           start_burst;

   assign burst_last  = (idx_ff + SW'(1)) >= SW'(burst_ff.packet_size);
   assign pay_rd_addr = base_ff + PAW'(idx_ff);
   assign slot_hit    = (state_ff == BK_SEND) && (slot_ff == tail_slot);
   assign start_burst = cmd_pop && (cmd.kind == KIND_TX_DATA);

   // next state
   always_comb begin
      unique case (state_ff)
         BK_IDLE: state_in = start_burst ? BK_SEND : BK_IDLE;
         BK_SEND: state_in = burst_last ? BK_IDLE : BK_SEND;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      cmd_pop      = 1'b0;
      idx_in       = idx_ff;
      out_valid_in = 1'b0;
      from_ram_in  = 1'b0;
      out_in       = out_ff;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_pop = !cmd_empty;
            idx_in  = '0;
            if (!cmd_empty && cmd.kind != KIND_TX_DATA) begin
               out_valid_in                 = 1'b1;
               out_in.result_kind           = cmd.kind;
               out_in.packet_id             = cmd.packet_id;
               out_in.packet_size           = cmd.packet_size;
               out_in.packet_final          = cmd.packet_final;
               out_in.out_byte              = cmd.out_byte;
               out_in.delivered_frame_end   = cmd.delivered_frame_end;
               out_in.last                  = 1'b1;
            end
         end
         BK_SEND: begin
            out_valid_in                = 1'b1;
            from_ram_in                 = 1'b1;
            out_in.result_kind          = KIND_TX_DATA;
            out_in.packet_id            = burst_ff.packet_id;
            out_in.packet_size          = burst_ff.packet_size;
            out_in.packet_final         = burst_ff.packet_final;
            out_in.out_byte             = '0;
            out_in.delivered_frame_end  = 1'b0;
            out_in.last                 = burst_last;
            idx_in                      = idx_ff + SW'(1);
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start_burst) begin
         burst_ff <= cmd;
         slot_ff  <= cmd_slot;
         base_ff  <= PAW'(cmd_slot) * PAW'(MAX_PAYLOAD);
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
         from_ram_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         from_ram_ff  <= from_ram_in;
      end
   end

   always_comb begin
      rsp_item = out_ff;
      if (from_ram_ff) begin
         rsp_item.out_byte = pay_rd_data;
      end
   end
   assign rsp_strobe = out_valid_ff;

   a_no_pop_in_burst: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SEND |-> !cmd_pop) else $error("command taken during burst");
   a_burst_ends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SEND && burst_last) |=> rsp_strobe && rsp_item.last)
      else $error("burst end without last mark");

endmodule

[tb/link_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_checker
// Watches the command, result and register ports of the stop-and-wait link,
// keeps its own model of the packet queue, the send timer and the receive
// side, and compares every result word against the oldest predicted one.
// ----------------------------------------------------------------------------
module link_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  slw_pkg::req_type        req_item,
   input  logic                    rsp_strobe,
   input  slw_pkg::rsp_type        rsp_item,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [slw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   input  logic                    csr_pready,
   output int                      fail_count,
   output int                      pending,
   output int                      queued_packets,
   output logic [15:0]             head_id,
   output int                      words_seen,
   output int                      results_seen
);
   import slw_pkg::*;

   localparam int MAXP = MAX_PAYLOAD_DEF;
   localparam int QD   = QUEUE_DEPTH_DEF;

   logic [7:0]  tx_store [QD*MAXP];
   logic [15:0] slot_id [QD];
   logic [4:0]  slot_size [QD];
   logic        slot_final [QD];
   int          q_head, q_tail, q_count;
   logic [15:0] next_id;
   int          build_len;
   logic        build_lost;
   logic [23:0] elapsed, timeout;
   logic        head_sent;
   int          rx_left;
   logic        rx_last_frame;
   rsp_type     expected_words[$];

   function automatic rsp_type make_word(kind_type k, logic [15:0] id, logic [4:0] sz,
                                         logic fin, logic [7:0] b, logic fe);
      rsp_type r;
      r.result_kind = k;
      r.packet_id = id;
      r.packet_size = sz;
      r.packet_final = fin;
      r.out_byte = b;
      r.delivered_frame_end = fe;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic expect_word(input rsp_type r);
      expected_words = {expected_words, r};
   endtask

   task automatic send_head_packet();
      rsp_type r;
      for (int i = 0; i < slot_size[q_head]; i++) begin
         r = make_word(KIND_TX_DATA, slot_id[q_head], slot_size[q_head],
                       slot_final[q_head], tx_store[q_head*MAXP+i], 1'b0);
         r.last = (i + 1 == slot_size[q_head]);
         expect_word(r);
      end
      head_sent = 1'b1;
      elapsed = '0;
   endtask

   task automatic predict_link(input req_type w);
      logic full;
      full = (q_count >= QD);
      case (op_type'(w.operation))
         OP_TX_BYTE: begin
            if (!full && build_len < MAXP)
               tx_store[q_tail*MAXP+build_len] = w.data_byte;
            else
               build_lost = 1'b1;
            build_len++;
            if (build_len >= MAXP || w.frame_end) begin
               if (full || build_lost)
                  expect_word(make_word(KIND_QUEUE_DROP, next_id,
                     5'(build_len), w.frame_end, 8'd0, 1'b0));
               else begin
                  slot_id[q_tail] = next_id;
                  slot_size[q_tail] = 5'(build_len);
                  slot_final[q_tail] = w.frame_end;
                  q_tail = (q_tail + 1) % QD;
                  q_count++;
                  next_id = next_id + 16'd1;
               end
               build_len = 0;
               build_lost = 1'b0;
            end
         end
         OP_TICK: begin
            if (q_count == 0)
               elapsed = '0;
            else if (!head_sent)
               send_head_packet();
            else begin
               if (elapsed != TICK_MAX)
                  elapsed++;
               if (elapsed > timeout)
                  send_head_packet();
            end
         end
         OP_RX_HEADER: begin
            if (w.rx_type == RX_DATA) begin
               rx_left = (w.rx_size > MAXP) ? MAXP : w.rx_size;
               rx_last_frame = w.rx_final;
               expect_word(make_word(KIND_TX_ACK, w.rx_id, 5'd0, 1'b0, 8'd0, 1'b0));
            end else if (w.rx_type == RX_ACK) begin
               if (q_count != 0 && slot_id[q_head] == w.rx_id) begin
                  expect_word(make_word(KIND_ACK_ACCEPTED, w.rx_id, 5'd0,
                                        1'b0, 8'd0, 1'b0));
                  q_head = (q_head + 1) % QD;
                  q_count--;
                  head_sent = 1'b0;
                  elapsed = '0;
               end else
                  expect_word(make_word(KIND_ACK_IGNORED, w.rx_id, 5'd0,
                                        1'b0, 8'd0, 1'b0));
            end
         end
         default: begin
            if (rx_left != 0) begin
               expect_word(make_word(KIND_DELIVER, 16'd0, 5'd0, 1'b0,
                  w.data_byte, rx_left == 1 && rx_last_frame));
               rx_left--;
            end
         end
      endcase
   endtask

   task automatic report(input string field, input int exp_val, input int got_val);
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field,
               exp_val, got_val);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         q_head = 0; q_tail = 0; q_count = 0; next_id = 16'd1;
         build_len = 0; build_lost = 1'b0; elapsed = '0; timeout = TIMEOUT_RESET;
         head_sent = 1'b0; rx_left = 0; rx_last_frame = 1'b0;
         expected_words.delete();
         fail_count = 0; words_seen = 0; results_seen = 0;
      end else begin
         if (rsp_strobe) begin
            results_seen++;
            if (expected_words.size() == 0)
               report("unexpected result word kind", 0, rsp_item.result_kind);
            else begin
               e = expected_words[0];
               expected_words.delete(0);
               if (rsp_item.result_kind != e.result_kind)
                  report("result_kind", e.result_kind, rsp_item.result_kind);
               if (rsp_item.packet_id != e.packet_id)
                  report("packet_id", e.packet_id, rsp_item.packet_id);
               if (rsp_item.packet_size != e.packet_size)
                  report("packet_size", e.packet_size, rsp_item.packet_size);
               if (rsp_item.packet_final != e.packet_final)
                  report("packet_final", e.packet_final, rsp_item.packet_final);
               if (rsp_item.out_byte != e.out_byte)
                  report("out_byte", e.out_byte, rsp_item.out_byte);
               if (rsp_item.delivered_frame_end != e.delivered_frame_end)
                  report("delivered_frame_end", e.delivered_frame_end,
                         rsp_item.delivered_frame_end);
               if (rsp_item.last != e.last)
                  report("last", e.last, rsp_item.last);
            end
         end
         if (start && !busy) begin
            words_seen++;
            predict_link(req_item);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_TIMEOUT)
            timeout = csr_pwdata[23:0];
      end
      pending = expected_words.size();
      queued_packets = q_count;
      head_id = slot_id[q_head];
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives frame bytes, ticks and received packets into the stop-and-wait link,
// changes the resend timeout between phases and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import slw_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   int fail_count, pending, queued_packets, words_seen, results_seen;
   logic [15:0] head_id;
   int idle_pct = 0;
   int stall_cycles = 0;

   always #6 clock = ~clock;

   segmenting_stop_and_wait_link uut (.*);

   link_checker chk (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic drive(input req_type w);
      int gap;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic tx_byte(input logic [7:0] b, input logic fend);
      req_type w;
      w = '0;
      w.operation = OP_TX_BYTE;
      w.data_byte = b;
      w.frame_end = fend;
      drive(w);
   endtask

   task automatic tick();
      req_type w;
      w = '0;
      w.operation = OP_TICK;
      drive(w);
   endtask

   task automatic header(input logic [1:0] t, input logic [15:0] id,
                         input logic [4:0] sz, input logic fin);
      req_type w;
      w = '0;
      w.operation = OP_RX_HEADER;
      w.rx_type = t;
      w.rx_id = id;
      w.rx_size = sz;
      w.rx_final = fin;
      drive(w);
   endtask

   task automatic rx_byte(input logic [7:0] b);
      req_type w;
      w = '0;
      w.operation = OP_RX_BYTE;
      w.data_byte = b;
      drive(w);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [23:0] value);
      settle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_TIMEOUT;
      csr_pwdata <= {8'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_word();
      req_type w;
      int pick;
      pick = $urandom_range(99);
      w = '0;
      if (pick < 40) begin
         w.operation = OP_TX_BYTE;
         w.data_byte = 8'($urandom_range(255));
         w.frame_end = ($urandom_range(5) == 0);
      end else if (pick < 60)
         w.operation = OP_TICK;
      else if (pick < 75) begin
         w.operation = OP_RX_HEADER;
         w.rx_type = RX_ACK;
         w.rx_id = ($urandom_range(9) < 7) ? head_id : 16'($urandom);
      end else if (pick < 85) begin
         w.operation = OP_RX_HEADER;
         w.rx_type = RX_DATA;
         w.rx_id = 16'($urandom);
         w.rx_size = 5'($urandom_range(31));
         w.rx_final = 1'($urandom_range(1));
      end else if (pick < 95) begin
         w.operation = OP_RX_BYTE;
         w.data_byte = 8'($urandom_range(255));
      end else
         w = req_type'($bits(req_type)'({$urandom, $urandom}));
      drive(w);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: segmenting, first send, acks
      tx_byte(8'h00, 1'b0);
      tx_byte(8'hFF, 1'b1);
      tick();
      tick();
      header(RX_ACK, 16'd5, 5'd0, 1'b0);
      header(RX_ACK, 16'd1, 5'd0, 1'b0);
      header(RX_ACK, 16'd1, 5'd0, 1'b0);
      tick();
      for (int i = 0; i < 30; i++)
         tx_byte(8'(i * 9), 1'b0);
      header(RX_ACK, 16'd2, 5'd0, 1'b0);
      // receive side: oversized size, restart mid payload, stray byte
      header(RX_DATA, 16'hFFFF, 5'd31, 1'b1);
      rx_byte(8'h12);
      rx_byte(8'h34);
      header(RX_DATA, 16'h8000, 5'd2, 1'b1);
      rx_byte(8'hAA);
      rx_byte(8'h55);
      rx_byte(8'h77);
      header(2'd2, 16'h1234, 5'd3, 1'b0);
      header(2'd3, 16'h4321, 5'd3, 1'b1);

      // zero timeout resends on every tick
      set_timeout(24'd0);
      tx_byte(8'hC3, 1'b1);
      tick();
      tick();
      tick();
      header(RX_ACK, 16'd3, 5'd0, 1'b0);

      // fill the queue, drop on full and after a lost byte
      set_timeout(24'hFFFFFF);
      for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++)
         tx_byte(8'($urandom), 1'b1);
      tick();
      tick();
      tx_byte(8'h5A, 1'b0);
      settle();
      header(RX_ACK, head_id, 5'd0, 1'b0);
      tx_byte(8'hA5, 1'b1);
      while (queued_packets != 0) begin
         settle();
         header(RX_ACK, head_id, 5'd0, 1'b0);
      end

      // random phases
      set_timeout(24'd1);
      idle_pct = 10;
      repeat (8) random_word();
      set_timeout(24'd3);
      idle_pct = 80;
      repeat (8) random_word();
      set_timeout(24'd100000);
      idle_pct = 0;
      repeat (8) random_word();

      settle();
      repeat (20) @(posedge clock);
      $display("covered %0d command words and %0d result words", words_seen, results_seen);
      $display("timeouts 0, 1, 3, 100000 and max; queue full and lost-byte drops");
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
